@@ hw/rtl/gcc_pkg.sv @@
// Shared widths, reset values and the bin word type for the GCC-PHAT bin weighting block.
// No dependencies; every other file in hw/rtl imports this package.
package gcc_pkg;

    // Sample width of one Q1.15 spectrum part
    localparam int SW       = 16;
    // Cross spectrum part width, Q3.30 signed
    localparam int QW       = 2 * SW + 1;
    // Magnitude and square root width
    localparam int MW       = 2 * SW;
    // Energy width, Q4.60
    localparam int EW       = 2 * MW;
    // Energy floor register width
    localparam int FLOOR_W  = 48;
    // Quotient width of the normalizing divide (one bit of headroom)
    localparam int QDW      = SW + 1;
    // Dividend width: magnitude shifted by SW-1 plus half the divisor
    localparam int NW       = MW + SW;

    localparam logic [FLOOR_W-1:0] FLOOR_RESET = 48'd1152921504607;

    // Cross spectrum bin traveling beside the energy and root
    typedef struct packed {
        logic signed [QW-1:0] re;
        logic signed [QW-1:0] im;
        logic                 last;
    } bin_t;

endpackage

@@ hw/rtl/gcc_phat_bin_weighting.sv @@
// GCC-PHAT bin weighting in three pipelines (4 cross spectrum/energy stages,
// 32 square root stages, 19 divide stages), one word accepted per cycle
// unless the output stalls; root and quotient bits form one per stage.
// Reset (rst_n low, asynchronous) empties the pipeline and loads the energy
// floor with its default of about 1e-6 in Q4.60.
module gcc_phat_bin_weighting (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [47:0] cfg_wdata,      // energy_floor
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // a_re, a_im, b_re, b_im
    input  logic        s_axis_tlast,   // last_bin
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // out_re, out_im
    output logic        m_axis_tlast    // out_last
);
    import gcc_pkg::*;

    logic [FLOOR_W-1:0] floor_reg;
    logic               x_valid, x_ready, r_valid, r_ready;
    bin_t               x_bin, r_bin;
    logic [EW-1:0]      x_energy;
    logic [MW-1:0]      r_root;
    logic signed [SW-1:0] o_re, o_im;

    // Hold the energy floor
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            floor_reg <= FLOOR_RESET;
        end
        else if (cfg_we)
        begin
            floor_reg <= cfg_wdata;
        end
    end

    gcc_xspec u_xspec (
        .clk          (clk),
        .rst_n        (rst_n),
        .energy_floor (floor_reg),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .a_re         (s_axis_tdata[15:0]),
        .a_im         (s_axis_tdata[31:16]),
        .b_re         (s_axis_tdata[47:32]),
        .b_im         (s_axis_tdata[63:48]),
        .last_bin     (s_axis_tlast),
        .out_valid    (x_valid),
        .out_ready    (x_ready),
        .out_bin      (x_bin),
        .out_energy   (x_energy)
    );

    gcc_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (x_valid),
        .in_ready  (x_ready),
        .in_bin    (x_bin),
        .in_energy (x_energy),
        .out_valid (r_valid),
        .out_ready (r_ready),
        .out_bin   (r_bin),
        .out_root  (r_root)
    );

    gcc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (r_valid),
        .in_ready  (r_ready),
        .in_bin    (r_bin),
        .in_root   (r_root),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_re    (o_re),
        .out_im    (o_im),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {o_im, o_re};

endmodule

@@ hw/rtl/gcc_xspec.sv @@
// Cross spectrum a*conj(b) and its energy plus floor, four pipeline stages.
// Depends on gcc_pkg.
module gcc_xspec (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [gcc_pkg::FLOOR_W-1:0]       energy_floor,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [gcc_pkg::SW-1:0]     a_re,
    input  logic signed [gcc_pkg::SW-1:0]     a_im,
    input  logic signed [gcc_pkg::SW-1:0]     b_re,
    input  logic signed [gcc_pkg::SW-1:0]     b_im,
    input  logic                              last_bin,
    output logic                              out_valid,
    input  logic                              out_ready,
    output gcc_pkg::bin_t                     out_bin,
    output logic [gcc_pkg::EW-1:0]            out_energy
);
    import gcc_pkg::*;

    localparam int NS = 4;

    logic [NS-1:0] v_reg;
    logic [NS:0]   rdy;

    logic signed [MW-1:0] p_rr_reg, p_ii_reg, p_ir_reg, p_ri_reg;
    logic                 last1_reg;
    bin_t                 bin2_reg, bin3_reg, bin4_reg;
    logic [MW-1:0]        mag_re, mag_im;
    logic [EW-1:0]        sq_re_next, sq_im_next;
    logic [EW-1:0]        sq_re_reg, sq_im_reg;
    logic [EW-1:0]        energy_reg;

    // Stall chain: a stage moves when it is empty or its successor moves
    always_comb
    begin
        rdy[NS] = out_ready;
        for (int k = NS - 1; k >= 0; k--)
        begin
            rdy[k] = !v_reg[k] || rdy[k+1];
        end
    end
    assign in_ready = rdy[0];

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int k = 1; k < NS; k++)
            begin
                if (rdy[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // Magnitudes of the cross parts for squaring
    always_comb
    begin
        mag_re     = MW'(bin2_reg.re[QW-1] ? -bin2_reg.re : bin2_reg.re);
        mag_im     = MW'(bin2_reg.im[QW-1] ? -bin2_reg.im : bin2_reg.im);
        sq_re_next = mag_re * mag_re;
        sq_im_next = mag_im * mag_im;
    end

    // Stage 1: partial products; stage 2: cross parts; stage 3: squares; stage 4: energy
    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            p_rr_reg  <= a_re * b_re;
            p_ii_reg  <= a_im * b_im;
            p_ir_reg  <= a_im * b_re;
            p_ri_reg  <= a_re * b_im;
            last1_reg <= last_bin;
        end
        if (rdy[1])
        begin
            bin2_reg.re   <= QW'(p_rr_reg) + QW'(p_ii_reg);
            bin2_reg.im   <= QW'(p_ir_reg) - QW'(p_ri_reg);
            bin2_reg.last <= last1_reg;
        end
        if (rdy[2])
        begin
            sq_re_reg <= sq_re_next;
            sq_im_reg <= sq_im_next;
            bin3_reg  <= bin2_reg;
        end
        if (rdy[3])
        begin
            energy_reg <= sq_re_reg + sq_im_reg + EW'(energy_floor);
            bin4_reg   <= bin3_reg;
        end
    end

    assign out_valid  = v_reg[NS-1];
    assign out_bin    = bin4_reg;
    assign out_energy = energy_reg;

endmodule

@@ hw/rtl/gcc_isqrt.sv @@
// Pipelined integer square root of the energy, one root bit per stage.
// Depends on gcc_pkg.
module gcc_isqrt (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  gcc_pkg::bin_t           in_bin,
    input  logic [gcc_pkg::EW-1:0]  in_energy,
    output logic                    out_valid,
    input  logic                    out_ready,
    output gcc_pkg::bin_t           out_bin,
    output logic [gcc_pkg::MW-1:0]  out_root
);
    import gcc_pkg::*;

    logic            v_reg    [MW];
    logic [MW:0]     rem_reg  [MW];
    logic [MW-1:0]   root_reg [MW];
    logic [EW-1:0]   e_reg    [MW];
    bin_t            bin_reg  [MW];
    logic [MW:0]     rdy;

    assign rdy[MW]  = out_ready;
    assign in_ready = rdy[0];

    for (genvar k = 0; k < MW; k++)
    begin : g_stage
        logic          v_in;
        logic [MW:0]   rem_in;
        logic [MW-1:0] root_in;
        logic [EW-1:0] e_in;
        bin_t          bin_in;
        logic [MW+2:0] rem_sh;
        logic [MW+2:0] trial;
        logic          ge;

        if (k == 0)
        begin : g_first
            assign v_in    = in_valid;
            assign rem_in  = '0;
            assign root_in = '0;
            assign e_in    = in_energy;
            assign bin_in  = in_bin;
        end
        else
        begin : g_next
            assign v_in    = v_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign e_in    = e_reg[k-1];
            assign bin_in  = bin_reg[k-1];
        end

        assign rdy[k] = !v_reg[k] || rdy[k+1];

        // Bring down the next two energy bits and try root*4+1
        always_comb
        begin
            rem_sh = {rem_in, e_in[EW-1:EW-2]};
            trial  = {1'b0, root_in, 2'b01};
            ge     = rem_sh >= trial;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (rdy[k])
            begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (rdy[k])
            begin
                rem_reg[k]  <= ge ? (MW+1)'(rem_sh - trial) : (MW+1)'(rem_sh);
                root_reg[k] <= {root_in[MW-2:0], ge};
                e_reg[k]    <= e_in << 2;
                bin_reg[k]  <= bin_in;
            end
        end
    end

    assign out_valid = v_reg[MW-1];
    assign out_bin   = bin_reg[MW-1];
    assign out_root  = root_reg[MW-1];

endmodule

@@ hw/rtl/gcc_div.sv @@
// Pipelined rounding divide of both cross parts by the root, with saturation.
// Depends on gcc_pkg.
module gcc_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  gcc_pkg::bin_t                  in_bin,
    input  logic [gcc_pkg::MW-1:0]         in_root,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [gcc_pkg::SW-1:0]  out_re,
    output logic signed [gcc_pkg::SW-1:0]  out_im,
    output logic                           out_last
);
    import gcc_pkg::*;

    // Prep stage, one stage per quotient bit, output stage
    localparam int NS = QDW + 2;

    typedef struct packed {
        logic [MW-1:0]  rem;
        logic [QDW-1:0] numlo;
        logic [QDW-1:0] q;
        logic           neg;
    } lane_t;

    typedef struct packed {
        lane_t         re;
        lane_t         im;
        logic [MW-1:0] m;
        logic          mz;
        logic          last;
    } div_t;

    logic [NS-1:0] v_reg;
    logic [NS:0]   rdy;
    div_t          d_reg [QDW+1];
    logic signed [SW-1:0] out_re_reg, out_im_reg;
    logic                 out_last_reg;

    // Set up rounded dividend |p|*2^(SW-1) + m/2 for one part
    function automatic lane_t lane_init(logic signed [QW-1:0] p, logic [MW-1:0] m);
        logic [MW-1:0] mag;
        logic [NW-1:0] num;
        lane_t         l;
        mag     = MW'(p[QW-1] ? -p : p);
        num     = (NW'(mag) << (SW - 1)) + NW'(m >> 1);
        l.rem   = MW'(num[NW-1:QDW]);
        l.numlo = num[QDW-1:0];
        l.q     = '0;
        l.neg   = p[QW-1];
        return l;
    endfunction

    // One restoring division step
    function automatic lane_t lane_step(lane_t l, logic [MW-1:0] m);
        logic [MW:0] rem2;
        logic        ge;
        lane_t       r;
        rem2    = {l.rem, l.numlo[QDW-1]};
        ge      = rem2 >= {1'b0, m};
        r.rem   = ge ? MW'(rem2 - {1'b0, m}) : MW'(rem2);
        r.numlo = l.numlo << 1;
        r.q     = {l.q[QDW-2:0], ge};
        r.neg   = l.neg;
        return r;
    endfunction

    // Clamp the quotient and apply the sign; a zero root gives zero
    function automatic logic signed [SW-1:0] lane_out(lane_t l, logic mz);
        logic [QDW-1:0] lim;
        logic [QDW-1:0] qc;
        logic signed [SW-1:0] r;
        lim = QDW'(1) << (SW - 1);
        qc  = (l.q > lim) ? lim : l.q;
        if (mz)
        begin
            r = '0;
        end
        else if (l.neg)
        begin
            r = SW'(-qc);
        end
        else
        begin
            r = (qc == lim) ? SW'(lim - QDW'(1)) : SW'(qc);
        end
        return r;
    endfunction

    always_comb
    begin
        rdy[NS] = out_ready;
        for (int k = NS - 1; k >= 0; k--)
        begin
            rdy[k] = !v_reg[k] || rdy[k+1];
        end
    end
    assign in_ready = rdy[0];

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int k = 1; k < NS; k++)
            begin
                if (rdy[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // Prep stage
    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            d_reg[0].re   <= lane_init(in_bin.re, in_root);
            d_reg[0].im   <= lane_init(in_bin.im, in_root);
            d_reg[0].m    <= in_root;
            d_reg[0].mz   <= (in_root == '0);
            d_reg[0].last <= in_bin.last;
        end
    end

    // Quotient bit stages
    for (genvar j = 1; j <= QDW; j++)
    begin : g_step
        always_ff @(posedge clk)
        begin
            if (rdy[j])
            begin
                d_reg[j].re   <= lane_step(d_reg[j-1].re, d_reg[j-1].m);
                d_reg[j].im   <= lane_step(d_reg[j-1].im, d_reg[j-1].m);
                d_reg[j].m    <= d_reg[j-1].m;
                d_reg[j].mz   <= d_reg[j-1].mz;
                d_reg[j].last <= d_reg[j-1].last;
            end
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (rdy[NS-1])
        begin
            out_re_reg   <= lane_out(d_reg[QDW].re, d_reg[QDW].mz);
            out_im_reg   <= lane_out(d_reg[QDW].im, d_reg[QDW].mz);
            out_last_reg <= d_reg[QDW].last;
        end
    end

    assign out_valid = v_reg[NS-1];
    assign out_re    = out_re_reg;
    assign out_im    = out_im_reg;
    assign out_last  = out_last_reg;

endmodule
